### hw/rtl/normalized_key_dual_fnv_hash_defines.svh
// Assertion macros for the normalized-key dual FNV hash block.
// Used by files that check internal invariants; no other dependencies.
`ifndef NORMALIZED_KEY_DUAL_FNV_HASH_DEFINES_SVH
`define NORMALIZED_KEY_DUAL_FNV_HASH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NKDF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nkdf: same-cycle invariant violated");
`define NKDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nkdf: next-cycle invariant violated");
`else
`define NKDF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define NKDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/nkdf_pkg.sv
// Package for the normalized-key dual FNV hash: constants, types, functions.
// No dependencies; the modules of the block import it and the interfaces refer to it.
package nkdf_pkg;

   localparam int BYTE_W = 8;
   localparam int LANE_W = 64;

   // The FNV prime is 2^40 + 435, so a multiply is a shift plus a narrow product.
   localparam logic [LANE_W-1:0] FNV_PRIME   = 64'd1099511628211;
   localparam int                PRIME_SHIFT = 40;
   localparam logic [8:0]        PRIME_LOW   = 9'd435;

   localparam logic [LANE_W-1:0] SALT_UPPER  = 64'h9E3779B97F4A7C15;
   localparam logic [LANE_W-1:0] SALT_LOWER  = 64'hC2B2AE3D27D4EB4F;
   localparam logic [LANE_W-1:0] BASIS_UPPER = 64'd1469598103934665603;
   localparam logic [LANE_W-1:0] BASIS_LOWER = 64'd14695981039346656037;
   localparam logic [BYTE_W-1:0] LOWER_ADD   = 8'h5B;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;

   localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_VT     = 8'h0B;
   localparam logic [BYTE_W-1:0] CHAR_FF     = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;

   // Queue between front and back; depth must be a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_W-1:0] char_code;  // case-folded byte
      logic              mix_space;  // hash one space before the byte
      logic              mix_char;   // hash the byte itself
      logic              last;       // end of name, produce a result
      logic              empty;      // normalized key has no characters
   } nkdf_op_type;

   typedef struct packed {
      logic        valid;
      nkdf_op_type op;
   } nkdf_slot_type;

   function automatic logic is_ws(input logic [BYTE_W-1:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_LF) ||
             (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
   endfunction

   function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
      return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ? b + CASE_OFFSET : b;
   endfunction

   function automatic logic [LANE_W-1:0] prime_mul(input logic [LANE_W-1:0] x);
      logic [LANE_W-1:0] low_part;
      low_part = x * {{(LANE_W-9){1'b0}}, PRIME_LOW};
      return (x << PRIME_SHIFT) + low_part;
   endfunction

endpackage

### hw/rtl/nkdf_if.sv
// Channel interfaces for the normalized-key dual FNV hash block.
// Depends on nkdf_pkg for field widths.
interface nkdf_req_if;
   logic                         valid;
   logic                         ready;
   logic [nkdf_pkg::BYTE_W-1:0]  name_byte;
   logic                         is_final;

   modport source (output valid, output name_byte, output is_final, input ready);
   modport sink   (input valid, input name_byte, input is_final, output ready);
endinterface

interface nkdf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [nkdf_pkg::LANE_W-1:0]  hash_upper;
   logic [nkdf_pkg::LANE_W-1:0]  hash_lower;
   logic                         key_empty;

   modport source (output valid, output hash_upper, output hash_lower,
                   output key_empty, input ready);
   modport sink   (input valid, input hash_upper, input hash_lower,
                   input key_empty, output ready);
endinterface

### hw/rtl/nkdf_queue.sv
// Small register queue of lane operations between the front and back ends.
// Depends on nkdf_pkg.
module nkdf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  nkdf_pkg::nkdf_slot_type push,
   output logic                   push_ready,
   output nkdf_pkg::nkdf_slot_type head,
   input  logic                   pop
);
   import nkdf_pkg::*;

   nkdf_op_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

### hw/rtl/nkdf_front.sv
// Front end: accepts raw name bytes, normalizes whitespace and case, and
// queues lane operations. Depends on nkdf_pkg and nkdf_if.
module nkdf_front (
   input  logic                    clock,
   input  logic                    reset,
   nkdf_req_if.sink                req_bus,
   output nkdf_pkg::nkdf_slot_type push,
   input  logic                    push_ready
);
   import nkdf_pkg::*;

   logic space_pending_ff, space_pending_in;
   logic key_started_ff, key_started_in;
   logic ws;
   logic accept;

   assign req_bus.ready = push_ready;

   always_comb begin
      ws     = is_ws(req_bus.name_byte);
      accept = req_bus.valid && push_ready;

      push.op.char_code = fold_case(req_bus.name_byte);
      push.op.mix_space = !ws && space_pending_ff;
      push.op.mix_char  = !ws;
      push.op.last      = req_bus.is_final;
      push.op.empty     = ws && !key_started_ff;
      // Whitespace that only marks a pending space needs no back-end work.
      push.valid        = accept && (!ws || req_bus.is_final);

      space_pending_in = space_pending_ff;
      key_started_in   = key_started_ff;
      if (accept) begin
         if (req_bus.is_final) begin
            space_pending_in = 1'b0;
            key_started_in   = 1'b0;
         end else if (ws) begin
            space_pending_in = space_pending_ff || key_started_ff;
         end else begin
            space_pending_in = 1'b0;
            key_started_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         space_pending_ff <= 1'b0;
         key_started_ff   <= 1'b0;
      end else begin
         space_pending_ff <= space_pending_in;
         key_started_ff   <= key_started_in;
      end
   end

endmodule

### hw/rtl/nkdf_back.sv
// Back end: both FNV-1a lanes, one shared mix step per cycle unless stalled;
// holds the result beat in an output register. Depends on nkdf_pkg, nkdf_if.
module nkdf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  nkdf_pkg::nkdf_slot_type head,
   output logic                    pop,
   nkdf_rsp_if.source              rsp_bus
);
   import nkdf_pkg::*;

   logic [LANE_W-1:0] upper_ff, upper_in;
   logic [LANE_W-1:0] lower_ff, lower_in;
   logic              space_done_ff, space_done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LANE_W-1:0] rsp_upper_ff, rsp_lower_ff;
   logic              rsp_empty_ff;

   logic              need_space;
   logic              slot_free;
   logic              load_rsp;
   logic [BYTE_W-1:0] mix_byte;
   logic [BYTE_W:0]   salted_sum;
   logic [LANE_W-1:0] upper_mixed, lower_mixed;
   logic [LANE_W-1:0] upper_done, lower_done;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.hash_upper = rsp_upper_ff;
   assign rsp_bus.hash_lower = rsp_lower_ff;
   assign rsp_bus.key_empty  = rsp_empty_ff;

   always_comb begin
      need_space = head.valid && head.op.mix_space && !space_done_ff;
      slot_free  = !rsp_valid_ff || rsp_bus.ready;

      mix_byte    = need_space ? CHAR_SPACE : head.op.char_code;
      salted_sum  = {1'b0, mix_byte} + {1'b0, LOWER_ADD};
      upper_mixed = prime_mul(upper_ff ^ SALT_UPPER ^ {{(LANE_W-BYTE_W){1'b0}}, mix_byte});
      lower_mixed = prime_mul(lower_ff ^ SALT_LOWER ^
                              {{(LANE_W-BYTE_W-1){1'b0}}, salted_sum});

      upper_done = head.op.mix_char ? upper_mixed : upper_ff;
      lower_done = head.op.mix_char ? lower_mixed : lower_ff;

      pop           = 1'b0;
      load_rsp      = 1'b0;
      upper_in      = upper_ff;
      lower_in      = lower_ff;
      space_done_in = space_done_ff;

      if (need_space) begin
         upper_in      = upper_mixed;
         lower_in      = lower_mixed;
         space_done_in = 1'b1;
      end else if (head.valid && (!head.op.last || slot_free)) begin
         pop           = 1'b1;
         space_done_in = 1'b0;
         if (head.op.last) begin
            load_rsp = 1'b1;
            upper_in = BASIS_UPPER;
            lower_in = BASIS_LOWER;
         end else begin
            upper_in = upper_done;
            lower_in = lower_done;
         end
      end

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff      <= BASIS_UPPER;
         lower_ff      <= BASIS_LOWER;
         space_done_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         upper_ff      <= upper_in;
         lower_ff      <= lower_in;
         space_done_ff <= space_done_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_upper_ff <= upper_done;
         rsp_lower_ff <= lower_done;
         rsp_empty_ff <= head.op.empty;
      end
   end

endmodule

### hw/rtl/normalized_key_dual_fnv_hash.sv
// Top level of the normalized-key dual FNV-1a hash block.
// Depends on nkdf_pkg, nkdf_if, nkdf_front, nkdf_queue, nkdf_back and the defines header.
//
// The block takes a name one byte per beat on req_bus, with is_final marking
// the last byte, and returns one beat on rsp_bus per name: two 64-bit FNV-1a
// lanes over the normalized key and a flag that is set when the key is empty.
// Normalization drops leading and trailing whitespace (space, tab, CR, LF, FF,
// VT), folds each inner run to one space, and lowers A-Z. The front end
// accepts one byte per cycle while its four-entry operation queue has room.
// The back end owns a single shared mix unit that advances both lanes once
// per cycle while it has work and is not stalled; a byte that ends an inner
// whitespace run takes a space mix step before the byte's own step, and
// whitespace that only marks a pending space needs no back-end work. The
// result beat appears in the output register the cycle after the last byte
// leaves the queue, and the back end keeps working on the next name while an
// unread result waits there; it stalls only when a second result is ready
// before the first is taken.
`include "normalized_key_dual_fnv_hash_defines.svh"

module normalized_key_dual_fnv_hash (
   input  logic       clock,
   input  logic       reset,
   nkdf_req_if.sink   req_bus,
   nkdf_rsp_if.source rsp_bus
);
   import nkdf_pkg::*;

   nkdf_slot_type push;
   nkdf_slot_type head;
   logic          push_ready;
   logic          pop;

   // Normalizer: whitespace and case handling, one byte per cycle while the queue has room.
   nkdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   // Decoupling queue so either side can stall on its own.
   nkdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   // Lane engine and result register.
   nkdf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

   // The back end never retires an operation the queue does not hold.
   `NKDF_ASSERT_IMPLIES(a_pop_has_head, clock, reset, pop, head.valid)
   // Taking a byte always leaves room for its queued operation.
   `NKDF_ASSERT_IMPLIES(a_push_has_room, clock, reset, push.valid, push_ready)
   // Retiring the last operation of a name presents a result beat next cycle.
   `NKDF_ASSERT_NEXT(a_last_gives_rsp, clock, reset, pop && head.op.last, rsp_bus.valid)
   // A held result beat keeps its lanes until it is taken.
   `NKDF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_bus.valid && !rsp_bus.ready,
                     rsp_bus.valid && $stable(rsp_bus.hash_upper))

endmodule
